/* rtl/nbc_pkg.sv */
// nbc_pkg: shared widths, register indexes and round functions for the nlfsr block cipher
// no dependencies; used by nbc_stage and nlfsr_block_cipher_32_64
package nbc_pkg;

    localparam int BLOCK_W          = 32;
    localparam int KEY_W            = 64;
    localparam int KEY_IDX_W        = 6;
    localparam int ENC_ROUNDS_W     = 10;
    localparam int ROUND_W          = 11;
    localparam int CFG_IDX_W        = 2;
    localparam int ROUNDS_PER_STAGE = 8;

    localparam logic [CFG_IDX_W-1:0]    REG_CIPHER_KEY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0]    REG_ENC_ROUNDS   = 2'd1;
    localparam logic [ENC_ROUNDS_W-1:0] ENC_ROUNDS_RESET = 10'd528;
    localparam logic [31:0]             NLF_TABLE        = 32'h3A5C742E;

    localparam logic KIND_ENCRYPT = 1'b0;
    localparam logic KIND_DECRYPT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [ROUND_W-1:0] rounds;
        logic [BLOCK_W-1:0] block;
    } pipe_t;

    function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] x,
                                                     input logic kb);
        logic [4:0] idx;
        logic       fb;
        idx = {x[31], x[26], x[20], x[9], x[1]};
        fb  = NLF_TABLE[idx] ^ x[16] ^ x[0] ^ kb;
        return {fb, x[31:1]};
    endfunction

    function automatic logic [BLOCK_W-1:0] dec_round(input logic [BLOCK_W-1:0] x,
                                                     input logic kb);
        logic [4:0] idx;
        logic       fb;
        idx = {x[30], x[25], x[19], x[8], x[0]};
        fb  = NLF_TABLE[idx] ^ x[15] ^ x[31] ^ kb;
        return {x[30:0], fb};
    endfunction

endpackage

/* rtl/nbc_stage.sv */
// nbc_stage: one pipeline stage running ROUNDS_PER_STAGE cipher rounds, masked by round count
// depends on nbc_pkg
module nbc_stage #(
    parameter int FIRST_ROUND = 0,
    parameter int FULL_ROUNDS = 528
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  nbc_pkg::pipe_t              in_item,
    input  logic [nbc_pkg::KEY_W-1:0]   key,
    output logic                        out_valid,
    output nbc_pkg::pipe_t              out_item
);
    import nbc_pkg::*;

    logic  valid_reg;
    pipe_t item_reg;
    pipe_t item_next;

    always_comb
    begin
        item_next = in_item;
        for (int j = 0; j < ROUNDS_PER_STAGE; j++)
        begin
            if (ROUND_W'(FIRST_ROUND + j) < in_item.rounds)
            begin
                if (in_item.kind == KIND_DECRYPT)
                    item_next.block = dec_round(item_next.block,
                        key[KEY_IDX_W'(FULL_ROUNDS - 1 - FIRST_ROUND - j)]);
                else
                    item_next.block = enc_round(item_next.block,
                        key[KEY_IDX_W'(FIRST_ROUND + j)]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/nlfsr_block_cipher_32_64.sv */
// nlfsr_block_cipher_32_64: fully unrolled pipelined nlfsr block cipher, 32-bit block, 64-bit key
// depends on nbc_pkg and nbc_stage
//
//  channel   signals                       content
//  s_*       s_tvalid s_tready s_tdata/user block_in in tdata, kind in tuser
//  m_*       m_tvalid m_tready m_tdata      block_out
//  cfg_*     cfg_wr_en cfg_index cfg_data   0 cipher_key, 1 encrypt_rounds
//
// one item enters per cycle while m_* is not stalled; each item passes all NUM_STAGES stages,
// a chain of stages with eight rounds each covering the longest round count
// reset clears all stage valid bits, the key to zero and encrypt_rounds to 528
// a result held at m_* freezes the whole chain, so s_tready falls with it
module nlfsr_block_cipher_32_64 #(
    parameter int FULL_ROUNDS = 528
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nbc_pkg::BLOCK_W-1:0]       s_tdata,   // [31:0] block_in
    input  logic                              s_tuser,   // [0] kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nbc_pkg::BLOCK_W-1:0]       m_tdata,   // [31:0] block_out
    input  logic                              cfg_wr_en,
    input  logic [nbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nbc_pkg::KEY_W-1:0]         cfg_data
);
    import nbc_pkg::*;

    localparam int ENC_MAX     = 2 ** ENC_ROUNDS_W - 1;
    localparam int ROUND_LIMIT = (FULL_ROUNDS > ENC_MAX) ? FULL_ROUNDS : ENC_MAX;
    localparam int NUM_STAGES  = (ROUND_LIMIT + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;

    logic [KEY_W-1:0]        key_reg;
    logic [ENC_ROUNDS_W-1:0] rounds_reg;
    logic                    en;
    logic [NUM_STAGES:0]     valid_vec;
    pipe_t                   item_in;
    pipe_t                   item_vec [NUM_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            rounds_reg <= ENC_ROUNDS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CIPHER_KEY: key_reg    <= cfg_data;
                REG_ENC_ROUNDS: rounds_reg <= cfg_data[ENC_ROUNDS_W-1:0];
                default: ;
            endcase
        end
    end

    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    always_comb
    begin
        item_in.kind   = s_tuser;
        item_in.rounds = (s_tuser == KIND_DECRYPT) ? ROUND_W'(FULL_ROUNDS)
                                                   : ROUND_W'(rounds_reg);
        item_in.block  = s_tdata;
    end

    assign valid_vec[0] = s_tvalid;
    assign item_vec[0]  = item_in;

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        nbc_stage #(
            .FIRST_ROUND (s * ROUNDS_PER_STAGE),
            .FULL_ROUNDS (FULL_ROUNDS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_vec[s]),
            .in_item   (item_vec[s]),
            .key       (key_reg),
            .out_valid (valid_vec[s+1]),
            .out_item  (item_vec[s+1])
        );
    end

    assign m_tvalid = valid_vec[NUM_STAGES];
    assign m_tdata  = item_vec[NUM_STAGES].block;

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (m_tready || !m_tvalid))
        else $error("s_tready does not follow the output stall");

    a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_vec[NUM_STAGES:1]))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> valid_vec[1])
        else $error("accepted item did not enter the first stage");

    a_rounds_written: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr_en && cfg_index == REG_ENC_ROUNDS)
            |=> rounds_reg == $past(cfg_data[ENC_ROUNDS_W-1:0]))
        else $error("encrypt_rounds write not taken");

endmodule
